FILE: rtl/core/sntc_pkg.sv
// Shared types, constants, the pair comparison and the level scaling for the texture code block.
`timescale 1ns / 1ps
`default_nettype none

package sntc_pkg;

    typedef logic [7:0] pixel_t;
    typedef logic [3:0] code_t;

    localparam int CFG_W       = 11;
    localparam int PAIRS       = 4;
    localparam int LEVEL_SCALE = 255;
    localparam int LEVEL_SHIFT = 4;
    localparam int MIN_WIDTH   = 3;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

    // Set when (a-b)+c+(a-c)*(b-c) is at least zero.
    function automatic logic pair_bit(input pixel_t a, input pixel_t b, input pixel_t c);
        logic signed [9:0]  ac;
        logic signed [9:0]  bc;
        logic signed [9:0]  ab;
        logic signed [19:0] prod;
        logic signed [19:0] sum;
        ac   = $signed({2'b00, a}) - $signed({2'b00, c});
        bc   = $signed({2'b00, b}) - $signed({2'b00, c});
        ab   = $signed({2'b00, a}) - $signed({2'b00, b});
        prod = ac * bc;
        sum  = prod + $signed({{10{ab[9]}}, ab}) + $signed({12'd0, c});
        return ~sum[19];
    endfunction

    // code*255/16
    function automatic pixel_t scale_level(input code_t code);
        logic [11:0] prod;
        prod = 12'(code) * 12'(LEVEL_SCALE);
        return prod[11:LEVEL_SHIFT];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/symmetric_neighbor_texture_code.sv
// Top level: 3x3 center-symmetric texture code over a raster pixel stream.
// Usage:
//   s_axis carries one gray pixel per transfer in raster order; tuser marks
//   the first pixel of a frame and restarts the column and row counters.
//   m_axis returns one result per input pixel, for the center one row up and
//   one column left: the 4-bit code, its display level code*255/16, and in
//   tuser a flag that is high only for interior centers (level and code are
//   zero otherwise). cfg_valid/cfg_data set the row width (3..MAX_LINE, out
//   of range values clamp); write it only while the stream is idle.
// Pipeline and throughput:
//   A result is formed in the input stage, where the line store is read,
//   and is then registered in the result register. One pixel is taken every
//   cycle while the output does not stall; the line store is read at the input
//   transfer and written as the item leaves the input stage, with a bypass
//   when the next pixel reads the column just written.
// Reset:
//   rst_n clears counters, window and valid flags, loads width 640; line store kept.
// Stall:
//   When m_axis_tready is low the result register holds, the input stage
//   holds behind it, and s_axis_tready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none

module symmetric_neighbor_texture_code
    import sntc_pkg::*;
#(
    parameter int MAX_LINE = 1024
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration: row width
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data,      // line_width
    // pixel stream in
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,  // [7:0] pixel
    input  wire logic              s_axis_tuser,  // [0] first_of_frame
    // result stream out
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [15:0]            m_axis_tdata,  // [7:0] level, [11:8] code, [15:12] zero
    output logic                   m_axis_tuser   // [0] window_valid
);

    localparam int AW      = $clog2(MAX_LINE);
    localparam int NEED_W  = $clog2(MAX_LINE + 1);
    localparam int WW      = (NEED_W > CFG_W) ? NEED_W : CFG_W;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [CFG_W-1:0] width_reg;
    logic [WW-1:0]    width_ext;
    logic [WW-1:0]    eff_width;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            width_reg <= cfg_data;
        end
    end

    // Clamp the row width into the supported range.
    always_comb
    begin
        width_ext = WW'(width_reg);
        if (width_ext < WW'(MIN_WIDTH))
        begin
            eff_width = WW'(MIN_WIDTH);
        end
        else if (width_ext > WW'(MAX_LINE))
        begin
            eff_width = WW'(MAX_LINE);
        end
        else
        begin
            eff_width = width_ext;
        end
    end

    // ---------------------------------------------------------------
    // Handshake chain: result register, then the input stage
    // ---------------------------------------------------------------
    logic a_valid_reg;
    logic out_valid_reg;
    logic out_adv;
    logic a_adv;
    logic in_xfer;

    assign out_adv       = ~out_valid_reg | m_axis_tready;
    assign a_adv         = a_valid_reg & out_adv;
    assign s_axis_tready = ~a_valid_reg | out_adv;
    assign in_xfer       = s_axis_tvalid & s_axis_tready;

    // ---------------------------------------------------------------
    // Column and row counters, advanced at each input transfer
    // ---------------------------------------------------------------
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic [1:0]    rows_reg;
    logic [1:0]    rows_next;
    logic [AW-1:0] col_cur;
    logic [1:0]    rows_cur;
    logic [WW-1:0] col_plus;
    logic          in_interior;

    always_comb
    begin
        col_cur  = s_axis_tuser ? '0 : col_reg;
        rows_cur = s_axis_tuser ? 2'd0 : rows_reg;
        col_plus = WW'(col_cur) + WW'(1);
        // drop to column zero at row end, count rows up to two
        if (col_plus >= eff_width)
        begin
            col_next  = '0;
            rows_next = (rows_cur == 2'd2) ? 2'd2 : rows_cur + 2'd1;
        end
        else
        begin
            col_next  = col_plus[AW-1:0];
            rows_next = rows_cur;
        end
        in_interior = (rows_cur == 2'd2) && (col_cur >= AW'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            rows_reg <= 2'd0;
        end
        else if (in_xfer)
        begin
            col_reg  <= col_next;
            rows_reg <= rows_next;
        end
    end

    // ---------------------------------------------------------------
    // Input stage registers
    // ---------------------------------------------------------------
    pixel_t        a_px_reg;
    logic [AW-1:0] a_col_reg;
    logic          a_interior_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_px_reg       <= s_axis_tdata;
            a_col_reg      <= col_cur;
            a_interior_reg <= in_interior;
        end
    end

    // ---------------------------------------------------------------
    // Line store: one entry per column, upper row in [15:8], middle in [7:0]
    // ---------------------------------------------------------------
    logic [15:0] line_mem [MAX_LINE];
    logic [15:0] rd_reg;
    logic [15:0] wr_data;
    logic        fwd_hit_reg;
    logic [15:0] fwd_data_reg;
    pixel_t      top;
    pixel_t      mid;

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            line_mem[a_col_reg] <= wr_data;
        end
        if (in_xfer)
        begin
            rd_reg <= line_mem[col_cur];
        end
    end

    // Bypass when the new pixel reads the column written at the same edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            fwd_hit_reg <= a_adv && (col_cur == a_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign top     = fwd_hit_reg ? fwd_data_reg[15:8] : rd_reg[15:8];
    assign mid     = fwd_hit_reg ? fwd_data_reg[7:0]  : rd_reg[7:0];
    assign wr_data = {mid, a_px_reg};

    // ---------------------------------------------------------------
    // Window: [0..2] column x-2 top/mid/bottom, [3..5] column x-1
    // ---------------------------------------------------------------
    pixel_t win_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (a_adv)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= a_px_reg;
        end
    end

    // ---------------------------------------------------------------
    // Code: four opposite pairs around the center win_reg[4]
    // ---------------------------------------------------------------
    pixel_t pair_a [PAIRS];
    pixel_t pair_b [PAIRS];
    code_t  code_raw;
    code_t  code_next;
    pixel_t level_next;

    always_comb
    begin
        pair_a[0] = mid;        pair_b[0] = win_reg[1];  // right / left
        pair_a[1] = a_px_reg;   pair_b[1] = win_reg[0];  // lower-right / upper-left
        pair_a[2] = win_reg[5]; pair_b[2] = win_reg[3];  // below / above
        pair_a[3] = win_reg[2]; pair_b[3] = top;         // lower-left / upper-right
        for (int k = 0; k < PAIRS; k++)
        begin
            code_raw[k] = pair_bit(pair_a[k], pair_b[k], win_reg[4]);
        end
        // zero the fields for border centers
        code_next  = a_interior_reg ? code_raw : '0;
        level_next = scale_level(code_next);
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    pixel_t out_level_reg;
    code_t  out_code_reg;
    logic   out_wv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            out_level_reg <= level_next;
            out_code_reg  <= code_next;
            out_wv_reg    <= a_interior_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_code_reg, out_level_reg};
    assign m_axis_tuser  = out_wv_reg;

endmodule

`default_nettype wire
